// ----- rtl/core/qhkl_pkg.sv -----
// ----------------------------------------------------------------------------
// qhkl_pkg
// shared widths, codes, constants and item types of the hkl coordinate block
// ----------------------------------------------------------------------------
package qhkl_pkg;

  // field widths
  localparam int unsigned FW    = 32;           // q and energy fields, result
  localparam int unsigned ROWW  = 63;           // one packed matrix row
  localparam int unsigned EW    = 21;           // one signed q4.16 entry
  localparam int unsigned PW    = 2 * EW;       // entry product, 2^-32
  localparam int unsigned SW    = PW + 3;       // sum of three products
  localparam int unsigned RSH   = 16;           // 2^-32 to 2^-16
  localparam int unsigned MW    = 27;           // rounded entry of m
  localparam int unsigned AW    = 55;           // adjugate entry
  localparam int unsigned ALW   = 28;           // low split of an adjugate entry
  localparam int unsigned AHW   = AW - ALW;     // high split, signed
  localparam int unsigned DETW  = 84;           // determinant
  localparam int unsigned CHW   = 28;           // chunk of |det| per multiplier
  localparam int unsigned NCH   = DETW / CHW;
  localparam int unsigned CW    = 32;           // 2 pi constant width
  localparam int unsigned DMAGW = DETW + CW;    // |2 pi det|
  localparam int unsigned NW    = 88;           // numerator, signed
  localparam int unsigned NMW   = NW - 1;       // numerator magnitude
  localparam int unsigned NSH   = 12;           // align numerator to the divisor
  localparam int unsigned RW    = DMAGW;        // partial remainder
  localparam int unsigned QW    = 34;           // quotient bits, one extra for rounding

  localparam int unsigned SETTLE = 9;           // derived matrix pipeline depth
  localparam int unsigned STW    = 4;

  localparam logic [CW-1:0] TWO_PI_Q29 = 32'hC90F_DAA2;
  localparam logic [FW-1:0] VAL_MAX    = 32'h7FFF_FFFF;
  localparam logic [FW-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [FW-1:0] VAL_ONE    = 32'h0001_0000;

  typedef enum logic [2:0] {
    SEL_QX     = 3'd0,
    SEL_QY     = 3'd1,
    SEL_QZ     = 3'd2,
    SEL_H      = 3'd3,
    SEL_K      = 3'd4,
    SEL_L      = 3'd5,
    SEL_ENERGY = 3'd6,
    SEL_UNITY  = 3'd7
  } sel_e;

  typedef enum logic [2:0] {
    CFG_SEL   = 3'd0,
    CFG_GON0  = 3'd1,
    CFG_GON1  = 3'd2,
    CFG_GON2  = 3'd3,
    CFG_UB0   = 3'd4,
    CFG_UB1   = 3'd5,
    CFG_UB2   = 3'd6
  } cfg_idx_e;

  // matrix-derived values; keeping them stable while items flow is left to the user
  typedef struct packed {
    logic [2:0][2:0][AW-1:0] adj;
    logic [DMAGW-1:0]        dmag;
    logic                    dneg;
    logic                    dzero;
  } mat_t;

  // item travelling through the divider
  typedef struct packed {
    logic          pass;
    logic [FW-1:0] pass_val;
    logic          nneg;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [QW-1:0] quo;
  } div_tok_t;

  function automatic logic signed [EW-1:0] entry(input logic [ROWW-1:0] row,
                                                 input logic [1:0] col);
    entry = $signed(row[col*EW +: EW]);
  endfunction

endpackage

// ----- rtl/core/qhkl_matrix.sv -----
// ----------------------------------------------------------------------------
// qhkl_matrix
// m = r * ub, its adjugate and |2 pi det|, free running from the registers
// ----------------------------------------------------------------------------
module qhkl_matrix import qhkl_pkg::*; (
  input  logic                      clk_i,
  input  logic [2:0][ROWW-1:0]      gonio_i,
  input  logic [2:0][ROWW-1:0]      ub_i,
  output mat_t                      mat_o
);

  logic signed [PW-1:0]        prod_q [3][3][3];
  logic signed [MW-1:0]        m_q    [3][3];
  logic signed [2*MW-1:0]      pa_q   [3][3];
  logic signed [2*MW-1:0]      pb_q   [3][3];
  logic signed [AW-1:0]        adj_q  [3][3];
  logic signed [MW+AHW-1:0]    dh_q   [3];
  logic signed [MW+ALW:0]      dl_q   [3];
  logic signed [DETW-1:0]      det_d, det_q;
  logic        [DETW-1:0]      dabs_q;
  logic                        dneg_q, dzero_q;
  logic        [CHW+CW-1:0]    dc_q   [NCH];
  logic        [DMAGW-1:0]     dmag_d, dmag_q;

  // stage 1: entry products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[i][j][k] <= entry(gonio_i[i], 2'(k)) * entry(ub_i[k], 2'(j));
        end
      end
    end
  end

  // stage 2: sum and round half up to 2^-16
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_q[i][j] <= MW'((SW'(prod_q[i][j][0]) + SW'(prod_q[i][j][1])
                          + SW'(prod_q[i][j][2]) + SW'(signed'(32768))) >>> RSH);
      end
    end
  end

  // stages 3 and 4: cofactor products and differences
  for (genvar i = 0; i < 3; i++) begin : g_ai
    for (genvar j = 0; j < 3; j++) begin : g_aj
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      always_ff @(posedge clk_i) begin
        pa_q[i][j]  <= m_q[J1][I1] * m_q[J2][I2];
        pb_q[i][j]  <= m_q[J1][I2] * m_q[J2][I1];
        adj_q[i][j] <= AW'(pa_q[i][j]) - AW'(pb_q[i][j]);
      end
      assign mat_o.adj[i][j] = adj_q[i][j];
    end
  end

  // stage 5: determinant partial products, adjugate split in two halves
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      dh_q[j] <= m_q[0][j] * $signed(adj_q[j][0][AW-1:ALW]);
      dl_q[j] <= m_q[0][j] * $signed({1'b0, adj_q[j][0][ALW-1:0]});
    end
  end

  always_comb begin
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DETW'(dh_q[j]) <<< ALW) + DETW'(dl_q[j]);
    end
  end

  // stages 6 and 7: determinant, magnitude and sign
  always_ff @(posedge clk_i) begin
    det_q   <= det_d;
    dabs_q  <= det_q[DETW-1] ? DETW'(-det_q) : DETW'(det_q);
    dneg_q  <= det_q[DETW-1];
    dzero_q <= (det_q == '0);
  end

  // stages 8 and 9: |det| times 2 pi in chunks
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NCH; c++) begin
      dc_q[c] <= dabs_q[c*CHW +: CHW] * TWO_PI_Q29;
    end
  end

  always_comb begin
    dmag_d = '0;
    for (int c = 0; c < NCH; c++) begin
      dmag_d = dmag_d + (DMAGW'(dc_q[c]) << (c * CHW));
    end
  end

  always_ff @(posedge clk_i) begin
    dmag_q <= dmag_d;
  end

  assign mat_o.dmag  = dmag_q;
  assign mat_o.dneg  = dneg_q;
  assign mat_o.dzero = dzero_q;

endmodule

// ----- rtl/core/qhkl_numer.sv -----
// ----------------------------------------------------------------------------
// qhkl_numer
// entry stages: pass-through decode, adjugate row times q, magnitude, range check
// ----------------------------------------------------------------------------
module qhkl_numer import qhkl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [FW-1:0]     q_x_i,
  input  logic [FW-1:0]     q_y_i,
  input  logic [FW-1:0]     q_z_i,
  input  logic [FW-1:0]     energy_i,
  input  sel_e              sel_i,
  input  mat_t              mat_i,
  output logic              valid_o,
  output div_tok_t          tok_o
);

  logic                        v0_q, v1_q, v2_q, v3_q;
  logic                        pass0_q, pass1_q, pass2_q;
  logic [FW-1:0]               pval0_q, pval1_q, pval2_q;
  logic signed [AHW+FW-1:0]    ph_q [3];
  logic signed [ALW+FW:0]      pl_q [3];
  logic signed [NW-1:0]        n_d, n_q;
  logic [NMW-1:0]              nmag_q;
  logic                        nneg_q;
  div_tok_t                    tok_q;

  logic                        pass_d;
  logic [FW-1:0]               pval_d;
  logic [1:0]                  row;
  logic signed [FW-1:0]        qv [3];
  logic [RW-1:0]               r0;
  logic                        ovf;

  assign qv[0] = $signed(q_x_i);
  assign qv[1] = $signed(q_y_i);
  assign qv[2] = $signed(q_z_i);

  always_comb begin
    pass_d = 1'b1;
    pval_d = '0;
    row    = 2'd0;
    unique case (sel_i)
      SEL_QX:     pval_d = q_x_i;
      SEL_QY:     pval_d = q_y_i;
      SEL_QZ:     pval_d = q_z_i;
      SEL_ENERGY: pval_d = energy_i;
      SEL_UNITY:  pval_d = VAL_ONE;
      SEL_H:      pass_d = 1'b0;
      SEL_K: begin
        pass_d = 1'b0;
        row    = 2'd1;
      end
      SEL_L: begin
        pass_d = 1'b0;
        row    = 2'd2;
      end
      default:    pass_d = 1'b1;
    endcase
  end

  always_comb begin
    n_d = '0;
    for (int j = 0; j < 3; j++) begin
      n_d = n_d + (NW'(ph_q[j]) <<< ALW) + NW'(pl_q[j]);
    end
  end

  // numerator aligned to the divisor; a quotient at or above 2^34 saturates
  assign r0  = RW'({nmag_q, {NSH{1'b0}}});
  assign ovf = (r0 >= mat_i.dmag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // partial products of the selected adjugate row
      for (int j = 0; j < 3; j++) begin
        ph_q[j] <= $signed(mat_i.adj[row][j][AW-1:ALW]) * qv[j];
        pl_q[j] <= $signed({1'b0, mat_i.adj[row][j][ALW-1:0]}) * qv[j];
      end
      pass0_q <= pass_d;
      pval0_q <= pval_d;

      n_q     <= n_d;
      pass1_q <= pass0_q;
      pval1_q <= pval0_q;

      nmag_q  <= n_q[NW-1] ? NMW'(-n_q) : NMW'(n_q);
      nneg_q  <= n_q[NW-1];
      pass2_q <= pass1_q;
      pval2_q <= pval1_q;

      tok_q.pass     <= pass2_q;
      tok_q.pass_val <= pval2_q;
      tok_q.nneg     <= nneg_q;
      tok_q.ovf      <= ovf;
      tok_q.rem      <= ovf ? '0 : r0;
      tok_q.quo      <= '0;
    end
  end

  assign valid_o = v3_q;
  assign tok_o   = tok_q;

endmodule

// ----- rtl/core/qhkl_divider.sv -----
// ----------------------------------------------------------------------------
// qhkl_divider
// restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module qhkl_divider import qhkl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [DMAGW-1:0]  dmag_i,
  input  logic              valid_i,
  input  div_tok_t          tok_i,
  output logic              valid_o,
  output div_tok_t          tok_o
);

  logic     v_q   [QW];
  div_tok_t tok_q [QW];
  logic     v_in  [QW];
  div_tok_t t_in  [QW];

  function automatic div_tok_t div_step(input div_tok_t t, input logic [RW-1:0] d);
    logic [RW:0] r2;
    logic [RW:0] dd;
    logic        ge;
    div_tok_t    o;
    r2    = {t.rem, 1'b0};
    dd    = {1'b0, d};
    ge    = (r2 >= dd);
    o     = t;
    o.rem = ge ? RW'(r2 - dd) : r2[RW-1:0];
    o.quo = {t.quo[QW-2:0], ge};
    return o;
  endfunction

  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign v_in[k] = valid_i;
      assign t_in[k] = tok_i;
    end else begin : g_next
      assign v_in[k] = v_q[k-1];
      assign t_in[k] = tok_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tok_q[k] <= div_step(t_in[k], dmag_i);
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign tok_o   = tok_q[QW-1];

endmodule

// ----- rtl/core/q_to_hkl_coordinate_select.sv -----
// ----------------------------------------------------------------------------
// q_to_hkl_coordinate_select
// throughput: one item per cycle while the skid entry is empty and the matrix has settled;
// the 34-stage quotient pipeline sets the depth
// reset, and every configuration write, hold s_axis_tready low while the derived
// matrix pipeline settles; reset loads selector H, matrices 0
// ----------------------------------------------------------------------------
module q_to_hkl_coordinate_select import qhkl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input items
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [127:0]      s_axis_tdata,   // q_x, q_y, q_z, energy_transfer
  // result items
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // coord_value
  output logic [0:0]        m_axis_tuser,   // singular_or_overflow
  // register writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [ROWW-1:0]   cfg_data_i
);

  typedef struct packed {
    logic [FW-1:0] value;
    logic          flag;
  } res_t;

  localparam logic [QW-1:0] MAG_POS_LIM = QW'(VAL_MAX);
  localparam logic [QW-1:0] MAG_NEG_LIM = QW'(VAL_MIN);

  // configuration registers
  sel_e                   sel_q;
  logic [2:0][ROWW-1:0]   gonio_q;
  logic [2:0][ROWW-1:0]   ub_q;
  logic [STW-1:0]         settle_q;
  logic                   cfg_wr;

  // pipeline control
  logic                   pipe_en;
  logic                   in_acc;
  mat_t                   mat;
  logic                   nv;
  div_tok_t               ntok;
  logic                   dv;
  div_tok_t               dtok;

  // output register and skid entry
  logic                   m_valid_q, sk_valid_q;
  res_t                   out_q, sk_q;
  res_t                   res;
  logic                   out_free;

  logic                   neg, negz;
  logic [QW:0]            qinc;
  logic [QW-1:0]          mag;
  logic [QW-1:0]          mag_neg;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q    <= SEL_H;
      gonio_q  <= '0;
      ub_q     <= '0;
      settle_q <= STW'(SETTLE);
    end else begin
      if (cfg_wr) begin
        settle_q <= STW'(SETTLE);
        unique case (cfg_index_i)
          CFG_SEL:  sel_q      <= sel_e'(cfg_data_i[2:0]);
          CFG_GON0: gonio_q[0] <= cfg_data_i;
          CFG_GON1: gonio_q[1] <= cfg_data_i;
          CFG_GON2: gonio_q[2] <= cfg_data_i;
          CFG_UB0:  ub_q[0]    <= cfg_data_i;
          CFG_UB1:  ub_q[1]    <= cfg_data_i;
          CFG_UB2:  ub_q[2]    <= cfg_data_i;
          default:  ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 1'b1;
      end
    end
  end

  // the whole pipeline advances together unless a result sits in the skid entry
  assign pipe_en       = !sk_valid_q;
  assign s_axis_tready = pipe_en && (settle_q == '0);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  qhkl_matrix u_matrix (
    .clk_i   (clk_i),
    .gonio_i (gonio_q),
    .ub_i    (ub_q),
    .mat_o   (mat)
  );

  qhkl_numer u_numer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (in_acc),
    .q_x_i    (s_axis_tdata[31:0]),
    .q_y_i    (s_axis_tdata[63:32]),
    .q_z_i    (s_axis_tdata[95:64]),
    .energy_i (s_axis_tdata[127:96]),
    .sel_i    (sel_q),
    .mat_i    (mat),
    .valid_o  (nv),
    .tok_o    (ntok)
  );

  qhkl_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .dmag_i  (mat.dmag),
    .valid_i (nv),
    .tok_i   (ntok),
    .valid_o (dv),
    .tok_o   (dtok)
  );

  // round the doubled quotient half up, then sign and saturate
  assign qinc    = {1'b0, dtok.quo} + 1'b1;
  assign mag     = qinc[QW:1];
  assign mag_neg = '0 - mag;
  assign neg     = dtok.nneg ^ mat.dneg;
  assign negz    = neg && (mag != '0);

  always_comb begin
    res.flag = 1'b0;
    if (dtok.pass) begin
      res.value = dtok.pass_val;
    end else if (mat.dzero) begin
      // singular matrix: sign follows the numerator alone
      res.value = dtok.nneg ? VAL_MIN : VAL_MAX;
      res.flag  = 1'b1;
    end else if (dtok.ovf) begin
      res.value = neg ? VAL_MIN : VAL_MAX;
      res.flag  = 1'b1;
    end else if (!negz && (mag > MAG_POS_LIM)) begin
      res.value = VAL_MAX;
      res.flag  = 1'b1;
    end else if (negz && (mag > MAG_NEG_LIM)) begin
      res.value = VAL_MIN;
      res.flag  = 1'b1;
    end else begin
      res.value = negz ? mag_neg[FW-1:0] : mag[FW-1:0];
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      sk_valid_q <= 1'b0;
    end else if (sk_valid_q) begin
      // pipeline frozen, drain the skid entry first
      if (out_free) begin
        m_valid_q  <= 1'b1;
        sk_valid_q <= 1'b0;
      end
    end else if (dv) begin
      if (out_free) begin
        m_valid_q <= 1'b1;
      end else begin
        sk_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (out_free) begin
        out_q <= sk_q;
      end
    end else if (dv) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        sk_q <= res;
      end
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = out_q.value;
  assign m_axis_tuser[0] = out_q.flag;

  // a skid entry only exists behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni) sk_valid_q |-> m_valid_q)
    else $error("skid entry valid without output valid");

  // the skid entry fills only when the output was stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(sk_valid_q) |-> $past(m_valid_q && !m_axis_tready))
    else $error("skid entry filled while output was free");

  // no item is taken right after a register write
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_wr |=> !s_axis_tready)
    else $error("input accepted before derived values settled");

endmodule

// ----- verif/tb_q_to_hkl_coordinate_select.sv -----
// ----------------------------------------------------------------------------
// tb_q_to_hkl_coordinate_select
// stream testbench: drives q and energy items under many selector and matrix
// settings and checks every result item against an independent predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_q_to_hkl_coordinate_select;
  import qhkl_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
  } coord_res_t;

  // predictor of the selected coordinate plus queue of pending results
  class coord_scoreboard;
    sel_e             sel_q;
    logic [62:0]      gon[3];
    logic [62:0]      ub[3];
    coord_res_t       pending_q[$];
    int               errors;

    function new();
      sel_q  = SEL_H;
      errors = 0;
      for (int i = 0; i < 3; i++) begin
        gon[i] = '0;
        ub[i]  = '0;
      end
    endfunction

    function void write_reg(cfg_idx_e idx, logic [62:0] data);
      case (idx)
        CFG_SEL:  sel_q  = sel_e'(data[2:0]);
        CFG_GON0: gon[0] = data;
        CFG_GON1: gon[1] = data;
        CFG_GON2: gon[2] = data;
        CFG_UB0:  ub[0]  = data;
        CFG_UB1:  ub[1]  = data;
        default:  ub[2]  = data;
      endcase
    endfunction

    function longint ent(logic [62:0] row, int c);
      logic signed [20:0] e;
      e = row[c*21 +: 21];
      return longint'(e);
    endfunction

    function coord_res_t hkl_value(logic [127:0] d);
      longint              m[3][3];
      longint              adj[3][3];
      longint              s;
      logic signed [127:0] den, num, a, b;
      logic [127:0]        an, ad;
      logic [199:0]        quo, rem, mag, dd;
      logic                neg;
      int                  row;
      coord_res_t          r;
      den = '0;
      num = '0;
      r.flag = 1'b0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          s = 0;
          for (int k = 0; k < 3; k++) s += ent(gon[i], k) * ent(ub[k], j);
          m[i][j] = (s + 32768) >>> 16;   // round half up
        end
      adj[0][0] = m[1][1]*m[2][2] - m[1][2]*m[2][1];
      adj[0][1] = m[0][2]*m[2][1] - m[0][1]*m[2][2];
      adj[0][2] = m[0][1]*m[1][2] - m[0][2]*m[1][1];
      adj[1][0] = m[1][2]*m[2][0] - m[1][0]*m[2][2];
      adj[1][1] = m[0][0]*m[2][2] - m[0][2]*m[2][0];
      adj[1][2] = m[0][2]*m[1][0] - m[0][0]*m[1][2];
      adj[2][0] = m[1][0]*m[2][1] - m[1][1]*m[2][0];
      adj[2][1] = m[0][1]*m[2][0] - m[0][0]*m[2][1];
      adj[2][2] = m[0][0]*m[1][1] - m[0][1]*m[1][0];
      // 2 pi det at 2^-77
      for (int j = 0; j < 3; j++) begin
        a = m[0][j] * longint'({32'd0, TWO_PI_Q29});
        b = adj[j][0];
        den += a * b;
      end
      row = int'(sel_q) - int'(SEL_H);
      for (int j = 0; j < 3; j++) begin
        a = adj[row][j];
        b = longint'($signed(d[j*32 +: 32]));
        num += a * b;
      end
      if (den == 0) begin
        r.value = (num < 0) ? VAL_MIN : VAL_MAX;
        r.flag  = 1'b1;
        return r;
      end
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      dd  = 200'(ad);
      quo = (200'(an) << 45) / dd;
      rem = (200'(an) << 45) % dd;
      if (quo > 200'h1_0000_0000) mag = 200'h1_0000_0000;
      else mag = quo + (((rem << 1) >= dd) ? 200'd1 : 200'd0);
      if (mag == 0) neg = 1'b0;
      if (!neg && mag > 200'h7FFF_FFFF) begin
        r.value = VAL_MAX;
        r.flag  = 1'b1;
      end else if (neg && mag > 200'h8000_0000) begin
        r.value = VAL_MIN;
        r.flag  = 1'b1;
      end else begin
        r.value = neg ? -mag[31:0] : mag[31:0];
      end
      return r;
    endfunction

    // accepted input item: work out its result
    function void note_point(logic [127:0] d);
      coord_res_t r;
      r.flag = 1'b0;
      case (sel_q)
        SEL_QX:     r.value = d[31:0];
        SEL_QY:     r.value = d[63:32];
        SEL_QZ:     r.value = d[95:64];
        SEL_ENERGY: r.value = d[127:96];
        SEL_UNITY:  r.value = VAL_ONE;
        default:    r = hkl_value(d);
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] value, logic flag);
      coord_res_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result item: coord_value %h flag %b", value, flag);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (e.value !== value) begin
        $error("coord_value: expected %h, actual %h", e.value, value);
        errors++;
      end
      if (e.flag !== flag) begin
        $error("singular_or_overflow: expected %b, actual %b", e.flag, flag);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [62:0]  cfg_data_i = '0;

  coord_scoreboard sb = new();
  bit              hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  q_to_hkl_coordinate_select u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // result side: sampled before the edge updates land
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
  end

  // receiver stalls, plus one long hold-off on request
  initial begin
    int r;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 9);
        m_axis_tready <= (r < 6);
        if (r < 6) repeat ($urandom_range(1, 25)) @(posedge clk_i);
        else if (r == 9) repeat ($urandom_range(20, 60)) @(posedge clk_i);
        else repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [62:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one item on the input stream, then an optional gap
  task automatic send_point(logic [127:0] d);
    int r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_point(d);
    r = $urandom_range(0, 19);
    if (r >= 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ((r == 19) ? $urandom_range(15, 50) : $urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // block idle: nothing outstanding and the pipeline drained
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_q(bit wide);
    if (wide) return $urandom();
    return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
  endfunction

  function automatic logic [20:0] rand_entry(int kind);
    case (kind)
      1:       return 21'($urandom());
      2:       return 21'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
      3:       return $urandom_range(0, 1) ? 21'h0F_FFFF : 21'h10_0000;
      default: return 21'd0;
    endcase
  endfunction

  // kind 0 scaled diagonal, 1 full random, 2 moderate, 3 extremes, 4 singular
  task automatic load_matrices(int kind);
    logic [62:0] g[3], u[3];
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        if (kind == 0) begin
          g[i][c*21 +: 21] = (i == c) ? 21'h1_0000 : 21'd0;
          u[i][c*21 +: 21] = (i == c) ? 21'($urandom_range(32'h800, 32'h3_0000)) : 21'd0;
        end else begin
          g[i][c*21 +: 21] = rand_entry(kind == 4 ? 2 : kind);
          u[i][c*21 +: 21] = rand_entry(kind == 4 ? 2 : kind);
        end
      end
    end
    if (kind == 4) g[2] = g[0];   // two equal rows of m: determinant zero
    write_reg(CFG_GON0, g[0]);
    write_reg(CFG_GON1, g[1]);
    write_reg(CFG_GON2, g[2]);
    write_reg(CFG_UB0, u[0]);
    write_reg(CFG_UB1, u[1]);
    write_reg(CFG_UB2, u[2]);
  endtask

  initial begin
    logic [31:0] ext[5];
    ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: H with zero matrices, every point singular
    for (int i = 0; i < 5; i++)
      send_point({ext[i], ext[(i+1)%5], ext[(i+2)%5], ext[(i+3)%5]});
    send_point({32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0});
    drain();

    // directed: pass-through, unity and a well-conditioned hkl setup
    load_matrices(0);
    for (int s = 0; s < 8; s++) begin
      write_reg(CFG_SEL, 63'(s));
      send_point({ext[s%5], ext[(s+1)%5], ext[(s+3)%5], ext[(s+4)%5]});
      send_point({rand_q(0), rand_q(0), rand_q(0), rand_q(0)});
      drain();
    end

    // random phases across selectors and matrix shapes
    // the hold-off phase carries more items than the pipeline holds
    for (int p = 0; p < 40; p++) begin
      load_matrices(p % 5);
      write_reg(CFG_SEL, 63'(p % 8));
      if (p == 13) hold_req = 1'b1;
      for (int n = 0; n < ((p == 13) ? 120 : 36); n++) begin
        bit wide;
        wide = $urandom_range(0, 2) == 0;
        send_point({$urandom(), rand_q(wide), rand_q(wide), rand_q(wide)});
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/qhkl_pkg.sv
rtl/core/qhkl_matrix.sv
rtl/core/qhkl_numer.sv
rtl/core/qhkl_divider.sv
rtl/core/q_to_hkl_coordinate_select.sv
verif/tb_q_to_hkl_coordinate_select.sv
